/* rtl/cau_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg
// Operation codes, status codes and internal datapath kinds for the
// complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MOD = 3'd4;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  // what the iterative stages do with an item
  typedef enum logic [1:0] {
    K_NONE = 2'd0,  // unknown opcode, result is zero
    K_PASS = 2'd1,  // add, subtract, multiply: magnitude already final
    K_DIV  = 2'd2,  // restoring divide on both lanes
    K_SQRT = 2'd3   // restoring square root on the real lane
  } kind_e;

endpackage
`default_nettype wire

/* rtl/complex_arithmetic_unit_core.sv */
// Throughput: one item per cycle while the output is not stalled; the divide and
//   square-root path resolves one result bit per stage over WORD_BITS stages.
// Stalls back-propagate stage by stage, so empty stages keep filling while the
//   output waits. Reset (rst_ni, async, active low) clears all valid bits only.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core
// Pipelined complex ALU on signed fixed point: add, subtract, multiply,
// divide and modulus, with saturation and divide-by-zero status.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_core #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // operation[2:0], a_re[34:3], a_im[66:35], b_re[98:67], b_im[130:99], zero pad
  input  wire logic [135:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // result_re[31:0], result_im[63:32], status[65:64], zero pad
  output logic [71:0]       m_axis_tdata
);
  import cau_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;          // products and squared magnitudes
  localparam int RW = 3 * W + F + 1;  // partial remainders
  localparam logic [PW-1:0] LIMIT = PW'(1) << (W - 1);
  localparam logic [31:0]   MAXV  = 32'((64'd1 << (W - 1)) - 64'd1);
  localparam logic [31:0]   MINV  = ~MAXV;

  // --------------------------------------------------------------------------
  // Handshake: each stage takes new data when it is empty or its successor
  // takes its content.
  // --------------------------------------------------------------------------
  logic v0_q, v1_q, v2_q, vo_q;
  logic v_it_q [0:W];
  logic rdy0, rdy1, rdy2, rdy_o;
  logic rdy_it [0:W];

  assign rdy_o = !vo_q || m_axis_tready;
  assign rdy_it[W] = !v_it_q[W] || rdy_o;
  for (genvar k = 0; k < W; k++) begin : g_rdy
    assign rdy_it[k] = !v_it_q[k] || rdy_it[k+1];
  end
  assign rdy2 = !v2_q || rdy_it[0];
  assign rdy1 = !v1_q || rdy2;
  assign rdy0 = !v0_q || rdy1;
  assign s_axis_tready = rdy0;

  // --------------------------------------------------------------------------
  // Stage 0: register operands, keeping the low WORD_BITS bits of each.
  // --------------------------------------------------------------------------
  logic [2:0]          op0_q;
  logic signed [W-1:0] ar0_q, ai0_q, br0_q, bi0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (rdy0) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0) begin
      op0_q <= s_axis_tdata[2:0];
      ar0_q <= s_axis_tdata[3 +: W];
      ai0_q <= s_axis_tdata[35 +: W];
      br0_q <= s_axis_tdata[67 +: W];
      bi0_q <= s_axis_tdata[99 +: W];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: products and plain sums. For modulus the first two multipliers
  // square the first operand.
  // --------------------------------------------------------------------------
  logic [2:0]           op1_q;
  logic signed [PW-1:0] pa_d, pb_d, pa_q, pb_q, pc_q, pd_q, pe_q, pf_q;
  logic signed [W:0]    sr_d, si_d, sr_q, si_q;

  always_comb begin
    pa_d = ar0_q * ((op0_q == OP_MOD) ? ar0_q : br0_q);
    pb_d = ai0_q * ((op0_q == OP_MOD) ? ai0_q : bi0_q);
    if (op0_q == OP_SUB) begin
      sr_d = (W+1)'(ar0_q) - (W+1)'(br0_q);
      si_d = (W+1)'(ai0_q) - (W+1)'(bi0_q);
    end else begin
      sr_d = (W+1)'(ar0_q) + (W+1)'(br0_q);
      si_d = (W+1)'(ai0_q) + (W+1)'(bi0_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      op1_q <= op0_q;
      pa_q  <= pa_d;
      pb_q  <= pb_d;
      pc_q  <= ar0_q * bi0_q;
      pd_q  <= ai0_q * br0_q;
      pe_q  <= br0_q * br0_q;
      pf_q  <= bi0_q * bi0_q;
      sr_q  <= sr_d;
      si_q  <= si_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: combine into sign and magnitude, squared divisor, zero check.
  // --------------------------------------------------------------------------
  logic signed [PW:0] xr, xi;
  logic [PW:0]        ur, ui;
  logic [PW-1:0]      den_d, mr_d, mi_d;
  kind_e              kind_d;
  logic [PW-1:0]      den2_q, mr2_q, mi2_q;
  logic               nr2_q, ni2_q, dz2_q;
  kind_e              kind2_q;

  always_comb begin
    xr     = '0;
    xi     = '0;
    kind_d = K_NONE;
    unique case (op1_q)
      OP_ADD, OP_SUB: begin
        xr     = (PW+1)'(sr_q);
        xi     = (PW+1)'(si_q);
        kind_d = K_PASS;
      end
      OP_MUL: begin
        xr     = (PW+1)'(pa_q) - (PW+1)'(pb_q);
        xi     = (PW+1)'(pc_q) + (PW+1)'(pd_q);
        kind_d = K_PASS;
      end
      OP_DIV: begin
        xr     = (PW+1)'(pa_q) + (PW+1)'(pb_q);
        xi     = (PW+1)'(pd_q) - (PW+1)'(pc_q);
        kind_d = K_DIV;
      end
      OP_MOD: begin
        xr     = (PW+1)'(pa_q) + (PW+1)'(pb_q);
        kind_d = K_SQRT;
      end
      default: ;
    endcase
    ur    = xr[PW] ? -xr : xr;
    ui    = xi[PW] ? -xi : xi;
    mr_d  = ur[PW-1:0];
    mi_d  = ui[PW-1:0];
    if (op1_q == OP_MUL) begin
      mr_d = mr_d >> F;
      mi_d = mi_d >> F;
    end
    den_d = PW'(pe_q) + PW'(pf_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      den2_q  <= den_d;
      mr2_q   <= mr_d;
      mi2_q   <= mi_d;
      nr2_q   <= xr[PW] && (mr_d != '0);
      ni2_q   <= xi[PW] && (mi_d != '0);
      dz2_q   <= (op1_q == OP_DIV) && (den_d == '0);
      kind2_q <= kind_d;
    end
  end

  // --------------------------------------------------------------------------
  // Iteration chain. Entry 0 is the set-up stage: scaled dividends and the
  // quotient overflow check. Entry j resolves result bit WORD_BITS-j.
  // --------------------------------------------------------------------------
  logic [RW-1:0] rem_re_q [0:W];
  logic [RW-1:0] rem_im_q [0:W];
  logic [PW-1:0] q_re_q   [0:W];
  logic [PW-1:0] q_im_q   [0:W];
  logic [PW-1:0] den_q    [0:W];
  logic          nr_q     [0:W];
  logic          ni_q     [0:W];
  logic          ovr_q    [0:W];
  logic          ovi_q    [0:W];
  logic          dz_q     [0:W];
  kind_e         kind_q   [0:W];

  logic [RW-1:0] scr, sci, dtop;
  logic          iter2;

  always_comb begin
    iter2 = (kind2_q == K_DIV) || (kind2_q == K_SQRT);
    scr   = (kind2_q == K_DIV) ? (RW'(mr2_q) << F) : RW'(mr2_q);
    sci   = RW'(mi2_q) << F;
    dtop  = RW'(den2_q) << W;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_it_q[0] <= 1'b0;
    end else if (rdy_it[0]) begin
      v_it_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_it[0]) begin
      rem_re_q[0] <= scr;
      rem_im_q[0] <= sci;
      q_re_q[0]   <= iter2 ? '0 : mr2_q;
      q_im_q[0]   <= iter2 ? '0 : mi2_q;
      den_q[0]    <= den2_q;
      nr_q[0]     <= nr2_q;
      ni_q[0]     <= ni2_q;
      ovr_q[0]    <= (kind2_q == K_DIV) && (scr >= dtop);
      ovi_q[0]    <= (kind2_q == K_DIV) && (sci >= dtop);
      dz_q[0]     <= dz2_q;
      kind_q[0]   <= kind2_q;
    end
  end

  for (genvar j = 1; j <= W; j++) begin : g_it
    localparam int SH = W - j;
    logic [RW-1:0] t_re, t_im, rem_re_d, rem_im_d;
    logic [PW-1:0] q_re_d, q_im_d;
    logic          hit_re, hit_im;

    // square root trial is root * 2^(SH+1) + 4^SH, divide trial is den * 2^SH
    always_comb begin
      if (kind_q[j-1] == K_SQRT) begin
        t_re = (RW'(q_re_q[j-1]) << (SH + 1)) + (RW'(1) << (2 * SH));
      end else begin
        t_re = RW'(den_q[j-1]) << SH;
      end
      t_im   = RW'(den_q[j-1]) << SH;
      hit_re = ((kind_q[j-1] == K_DIV) || (kind_q[j-1] == K_SQRT))
               && (rem_re_q[j-1] >= t_re);
      hit_im = (kind_q[j-1] == K_DIV) && (rem_im_q[j-1] >= t_im);
      rem_re_d = hit_re ? rem_re_q[j-1] - t_re : rem_re_q[j-1];
      rem_im_d = hit_im ? rem_im_q[j-1] - t_im : rem_im_q[j-1];
      q_re_d   = hit_re ? (q_re_q[j-1] | (PW'(1) << SH)) : q_re_q[j-1];
      q_im_d   = hit_im ? (q_im_q[j-1] | (PW'(1) << SH)) : q_im_q[j-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_it_q[j] <= 1'b0;
      end else if (rdy_it[j]) begin
        v_it_q[j] <= v_it_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy_it[j]) begin
        rem_re_q[j] <= rem_re_d;
        rem_im_q[j] <= rem_im_d;
        q_re_q[j]   <= q_re_d;
        q_im_q[j]   <= q_im_d;
        den_q[j]    <= den_q[j-1];
        nr_q[j]     <= nr_q[j-1];
        ni_q[j]     <= ni_q[j-1];
        ovr_q[j]    <= ovr_q[j-1];
        ovi_q[j]    <= ovi_q[j-1];
        dz_q[j]     <= dz_q[j-1];
        kind_q[j]   <= kind_q[j-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: clamp to the signed word range, sign extend, set status.
  // A quotient overflow becomes LIMIT + 1, which always clamps.
  // --------------------------------------------------------------------------
  logic [PW-1:0] fr, fi, cr, ci;
  logic          sat_r, sat_i;
  logic [W-1:0]  wr, wi;
  logic [31:0]   res_re_d, res_im_d;
  status_e       st_d;
  logic [31:0]   res_re_q, res_im_q;
  status_e       st_q;

  always_comb begin
    fr    = ovr_q[W] ? LIMIT + PW'(1) : q_re_q[W];
    fi    = ovi_q[W] ? LIMIT + PW'(1) : q_im_q[W];
    cr    = fr;
    ci    = fi;
    sat_r = 1'b0;
    sat_i = 1'b0;
    if (!nr_q[W] && fr > LIMIT - PW'(1)) begin
      sat_r = 1'b1;
      cr    = LIMIT - PW'(1);
    end else if (nr_q[W] && fr > LIMIT) begin
      sat_r = 1'b1;
      cr    = LIMIT;
    end
    if (!ni_q[W] && fi > LIMIT - PW'(1)) begin
      sat_i = 1'b1;
      ci    = LIMIT - PW'(1);
    end else if (ni_q[W] && fi > LIMIT) begin
      sat_i = 1'b1;
      ci    = LIMIT;
    end
    wr = nr_q[W] ? -cr[W-1:0] : cr[W-1:0];
    wi = ni_q[W] ? -ci[W-1:0] : ci[W-1:0];
    res_re_d = 32'($signed(wr));
    res_im_d = 32'($signed(wi));
    st_d     = (sat_r || sat_i) ? ST_SAT : ST_OK;
    if (dz_q[W]) begin
      res_re_d = '0;
      res_im_d = '0;
      st_d     = ST_DIV0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (rdy_o) begin
      vo_q <= v_it_q[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o) begin
      res_re_q <= res_re_d;
      res_im_q <= res_im_d;
      st_q     <= st_d;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {6'd0, st_q, res_im_q, res_re_q};

`ifndef SYNTH
  a_div0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q && st_q == ST_DIV0 |-> res_re_q == '0 && res_im_q == '0)
    else $error("divide-by-zero result not zero");

  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q && st_q == ST_SAT |->
      res_re_q == MAXV || res_re_q == MINV || res_im_q == MAXV || res_im_q == MINV)
    else $error("saturation status without a clamped part");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vo_q |-> s_axis_tready)
    else $error("input stalled with an empty output stage");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v0_q && !rdy1 |=> v0_q)
    else $error("stalled first stage lost its item");
`endif

endmodule
`default_nettype wire
